### src/polygon_point_containment_nearest_edge_macros.svh
// Assertion macros for the polygon containment block.
`ifndef POLYGON_POINT_CONTAINMENT_NEAREST_EDGE_MACROS_SVH
`define POLYGON_POINT_CONTAINMENT_NEAREST_EDGE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define PPCNE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define PPCNE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PPCNE_ASSERT_SAME(label, clk, rst, ante, cons)
`define PPCNE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/ppcne_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ppcne_pkg;
  // Table depths and coordinate width.
  localparam int NumVertices = 256;
  localparam int NumEdges    = 256;
  localparam int CoordBits   = 16;
  localparam int IdxBits     = 8;
  localparam int CountBits   = 9;
  localparam int InDataBits  = 56;
  localparam int OutDataBits = 96;
  localparam int DivSteps    = 17;

  // Input operation codes carried in tuser.
  localparam logic [1:0] FUNC_WR_VERTEX = 2'd0;
  localparam logic [1:0] FUNC_WR_EDGE   = 2'd1;
  localparam logic [1:0] FUNC_QUERY     = 2'd2;
endpackage
`default_nettype wire

### src/polygon_point_containment_nearest_edge.sv
`timescale 1ns / 1ps
`default_nettype none
// Point-in-polygon test with nearest-edge search.
// The s_axis channel carries write and query items; tuser holds the operation
// (write vertex, write edge, query point) and tdata holds index, x, y, end_a
// and end_b. Every transfer in produces exactly one transfer on m_axis.
// Writes answer with an all-zero result on the cycle after the transfer.
// A query walks edges 0 to edge_count-1 (at most 256) with one shared 19x19
// multiplier and a one-bit-per-cycle divider. Each edge passes through the
// edge read, vertex reads, setup, multiply and check states, plus 17 divider
// steps and 6 projection steps when its projection falls on the segment.
// The input is not ready while a query runs. A finished result waits in the
// output register; a new item is taken only when that register can be loaded
// or is drained in the same cycle. When the receiver stalls, the query result
// is held in its final step until the output register frees up.
// The user must write the edge_count register (edge_count_we) only while idle;
// the block does not enforce it. Reset (rst, synchronous) clears edge_count,
// the sequencer and output valid; vertex/edge tables are undefined until written.
module polygon_point_containment_nearest_edge (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           edge_count_we,
  input  wire logic [ppcne_pkg::CountBits-1:0] edge_count_wdata,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // index[7:0], x[23:8], y[39:24], end_a[47:40], end_b[55:48]
  input  wire logic [ppcne_pkg::InDataBits-1:0] s_axis_tdata,
  // func[1:0]
  input  wire logic [1:0]                      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // inside_res[0], found[1], nearest_edge[9:2], edge_param[26:10],
  // dist_sq[59:27], proj_x[75:60], proj_y[91:76], zero[95:92]
  output logic [ppcne_pkg::OutDataBits-1:0]    m_axis_tdata
);
  import ppcne_pkg::*;
`include "polygon_point_containment_nearest_edge_macros.svh"

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_EDGE_RD = 10'b0000000010,
    S_VA_RD   = 10'b0000000100,
    S_VB_RD   = 10'b0000001000,
    S_SETUP   = 10'b0000010000,
    S_MUL     = 10'b0000100000,
    S_CHECK   = 10'b0001000000,
    S_DIV     = 10'b0010000000,
    S_PROJ    = 10'b0100000000,
    S_OUT     = 10'b1000000000
  } state_t;

  state_t state;
  logic [CountBits-1:0] edge_count;
  logic [CountBits-1:0] n_edges;
  logic [CountBits-1:0] e_idx;
  logic [2:0] step;
  logic [4:0] div_cnt;

  logic [2*CoordBits-1:0] vtx_mem [NumVertices];
  logic [2*IdxBits-1:0]   edge_mem [NumEdges];
  logic [2*CoordBits-1:0] vtx_rdata;
  logic [2*IdxBits-1:0]   edge_rdata;
  logic [IdxBits-1:0]     vtx_raddr;

  logic signed [CoordBits-1:0] px, py, p1x, p1y;
  logic signed [CoordBits:0]   dx, dy, rx, ry;
  logic in_span;
  logic signed [35:0] cr, l2, dot;
  logic [36:0] rem;
  logic [16:0] q, t, t_src;
  logic signed [17:0] qx, qy;
  logic [35:0] d;
  logic signed [18:0] mul_a, mul_b;
  logic signed [37:0] prod;

  logic inside_par, found;
  logic [IdxBits-1:0] best_e;
  logic [16:0] best_t;
  logic [35:0] best_d;
  logic [CoordBits-1:0] best_x, best_y;

  logic s_xfer, out_free, out_load;
  logic [1:0] func;

  assign func     = s_axis_tuser;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && out_free;
  assign s_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_load = (state == S_IDLE && s_xfer && func != FUNC_QUERY) ||
                    (state == S_OUT && out_free);

  // Vertex and edge tables: written on transfer, read one address a cycle.
  assign vtx_raddr = (state == S_VA_RD) ? edge_rdata[IdxBits-1:0]
                                        : edge_rdata[2*IdxBits-1:IdxBits];
  always_ff @(posedge clk) begin
    if (s_xfer && func == FUNC_WR_VERTEX) begin
      vtx_mem[s_axis_tdata[7:0]] <= s_axis_tdata[39:8];
    end
    vtx_rdata <= vtx_mem[vtx_raddr];
  end
  always_ff @(posedge clk) begin
    if (s_xfer && func == FUNC_WR_EDGE) begin
      edge_mem[s_axis_tdata[7:0]] <= s_axis_tdata[55:40];
    end
    if (state == S_EDGE_RD) begin
      edge_rdata <= edge_mem[e_idx[IdxBits-1:0]];
    end
  end

  // Differences from the closest point to the query point.
  logic signed [18:0] ex, ey;
  assign ex = 19'(px) - 19'(qx);
  assign ey = 19'(py) - 19'(qy);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_MUL) begin
      case (step)
        3'd0: begin mul_a = 19'(rx); mul_b = 19'(dy); end
        3'd1: begin mul_a = 19'(dx); mul_b = 19'(ry); end
        3'd2: begin mul_a = 19'(dx); mul_b = 19'(dx); end
        3'd3: begin mul_a = 19'(dy); mul_b = 19'(dy); end
        3'd4: begin mul_a = 19'(rx); mul_b = 19'(dx); end
        3'd5: begin mul_a = 19'(ry); mul_b = 19'(dy); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state == S_PROJ) begin
      case (step)
        3'd0: begin mul_a = 19'(dx); mul_b = $signed({2'b00, t_src}); end
        3'd1: begin mul_a = 19'(dy); mul_b = $signed({2'b00, t_src}); end
        3'd2: begin mul_a = ex; mul_b = ex; end
        3'd3: begin mul_a = ey; mul_b = ey; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Rounded projection offset: floor((prod + 32768) / 65536).
  logic signed [37:0] rsum, rsh;
  assign rsum = prod + 38'sd32768;
  assign rsh  = rsum >>> 16;

  // Division step and edge bookkeeping.
  logic [36:0] rem2, l2u;
  logic [16:0] q_next;
  logic [17:0] q_inc;
  logic last_edge;
  assign rem2  = {rem[35:0], 1'b0};
  assign l2u   = {1'b0, l2};
  assign q_next = (rem2 >= l2u) ? {q[15:0], 1'b1} : {q[15:0], 1'b0};
  assign q_inc = {1'b0, q} + 18'd1;
  assign last_edge = (e_idx + 9'd1) == n_edges;
  // In the first projection step t is not loaded yet, so take it from the divider.
  assign t_src = (step == 3'd0) ? q_inc[17:1] : t;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
    end else if (edge_count_we) begin
      edge_count <= edge_count_wdata;
    end
  end

  // Output valid: set when a result is loaded, cleared when it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      div_cnt <= '0;
      e_idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_xfer) begin
            px <= $signed(s_axis_tdata[23:8]);
            py <= $signed(s_axis_tdata[39:24]);
            inside_par <= 1'b0;
            found <= 1'b0;
            best_e <= '0;
            best_t <= '0;
            best_d <= '0;
            best_x <= '0;
            best_y <= '0;
            e_idx <= '0;
            n_edges <= (edge_count > 9'(NumEdges)) ? 9'(NumEdges) : edge_count;
            if (func == FUNC_QUERY) begin
              state <= (edge_count == '0) ? S_OUT : S_EDGE_RD;
            end else begin
              m_axis_tdata <= '0;
            end
          end
        end
        S_EDGE_RD: state <= S_VA_RD;
        S_VA_RD:   state <= S_VB_RD;
        S_VB_RD: begin
          p1x <= $signed(vtx_rdata[15:0]);
          p1y <= $signed(vtx_rdata[31:16]);
          state <= S_SETUP;
        end
        S_SETUP: begin
          dx <= 17'($signed(vtx_rdata[15:0])) - 17'(p1x);
          dy <= 17'($signed(vtx_rdata[31:16])) - 17'(p1y);
          rx <= 17'(px) - 17'(p1x);
          ry <= 17'(py) - 17'(p1y);
          in_span <= !((py < p1y && py < $signed(vtx_rdata[31:16])) ||
                       (py > p1y && py > $signed(vtx_rdata[31:16])));
          step <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          // Consume the product issued one step earlier.
          case (step)
            3'd1: cr  <= 36'(prod);
            3'd2: cr  <= cr - 36'(prod);
            3'd3: l2  <= 36'(prod);
            3'd4: l2  <= l2 + 36'(prod);
            3'd5: dot <= 36'(prod);
            3'd6: dot <= dot + 36'(prod);
            default: ;
          endcase
          step <= step + 3'd1;
          if (step == 3'd6) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          // Even-odd crossing rule.
          if (in_span && !((cr > 0 && dy > 0) || (cr < 0 && dy < 0))) begin
            inside_par <= !inside_par;
          end
          rem <= 37'(dot);
          q <= '0;
          div_cnt <= '0;
          if (l2 == 0 || dot < 0 || dot > l2) begin
            if (last_edge) begin
              state <= S_OUT;
            end else begin
              e_idx <= e_idx + 9'd1;
              state <= S_EDGE_RD;
            end
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= (rem2 >= l2u) ? rem2 - l2u : rem2;
          q <= q_next;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'(DivSteps - 1)) begin
            step <= '0;
            state <= S_PROJ;
          end
        end
        S_PROJ: begin
          if (step == 3'd0) begin
            t <= q_inc[17:1];
          end
          case (step)
            3'd1: qx <= 18'(p1x) + rsh[17:0];
            3'd2: qy <= 18'(p1y) + rsh[17:0];
            3'd3: d  <= 36'(prod);
            3'd4: d  <= d + 36'(prod);
            default: ;
          endcase
          step <= step + 3'd1;
          if (step == 3'd5) begin
            // Keep the first edge on equal distance.
            if (!found || d < best_d) begin
              found <= 1'b1;
              best_e <= e_idx[IdxBits-1:0];
              best_t <= t;
              best_d <= d;
              best_x <= qx[15:0];
              best_y <= qy[15:0];
            end
            if (last_edge) begin
              state <= S_OUT;
            end else begin
              e_idx <= e_idx + 9'd1;
              state <= S_EDGE_RD;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tdata <= {4'b0, best_y, best_x, best_d[32:0], best_t,
                             best_e, found, inside_par};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PPCNE_ASSERT_NEXT(a_write_answers, clk, rst, s_xfer && func != FUNC_QUERY, m_axis_tvalid)
  `PPCNE_ASSERT_SAME(a_div_bound, clk, rst, state == S_DIV, div_cnt < 5'(DivSteps))
  `PPCNE_ASSERT_SAME(a_edge_bound, clk, rst, state == S_EDGE_RD, e_idx < n_edges)
  `PPCNE_ASSERT_SAME(a_best_bound, clk, rst, state == S_OUT && found, {1'b0, best_e} < n_edges)
endmodule
`default_nettype wire
